// ----- hdl/tomasulo_reservation_pools_assert.svh -----
// Assertion macros for the reservation pool block
`ifndef TOMASULO_RESERVATION_POOLS_ASSERT_SVH
`define TOMASULO_RESERVATION_POOLS_ASSERT_SVH
`define TP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define TP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hdl/tp_pkg.sv -----
// Types, constants and opcode decode for the reservation pools
package tp_pkg;
  localparam int SLOTS_PER_POOL = 8;
  localparam int TAG_COUNT      = 32;
  localparam int POOL_COUNT     = 5;
  localparam int NSLOTS         = POOL_COUNT * SLOTS_PER_POOL;
  localparam int LS_POOL        = 4;
  localparam int RES_MAX        = 5;

  typedef enum logic [1:0] {
    FN_CLEAR    = 2'd0,
    FN_DISPATCH = 2'd1,
    FN_WAKEUP   = 2'd2,
    FN_ISSUE    = 2'd3
  } func_t;

  localparam logic [2:0] KIND_ACCEPT  = 3'd0;
  localparam logic [2:0] KIND_FULL    = 3'd1;
  localparam logic [2:0] KIND_UNKNOWN = 3'd2;
  localparam logic [2:0] KIND_ALU     = 3'd3;
  localparam logic [2:0] KIND_LOAD    = 3'd4;
  localparam logic [2:0] KIND_STORE   = 3'd5;

  localparam logic [5:0] OP_LAST_LOAD = 6'd30;

  typedef struct packed {
    func_t       func;
    logic [5:0]  op;
    logic        src1_pending;
    logic [4:0]  src1_tag;
    logic [31:0] src1_value;
    logic        src2_pending;
    logic [4:0]  src2_tag;
    logic [31:0] src2_value;
    logic [31:0] imm;
    logic [4:0]  rob_tag;
    logic [4:0]  unit_free;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  pool;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [4:0]  dest_tag;
    logic [5:0]  op_out;
    logic [4:0]  full_mask;
    logic        last;
  } out_t;

  // pool of an opcode; valid flag low for unknown opcodes
  function automatic logic [3:0] pool_of(input logic [5:0] op);
    logic [3:0] r;
    if (op <= 6'd3)       r = {1'b1, 3'd0};
    else if (op <= 6'd13) r = {1'b1, 3'd1};
    else if (op <= 6'd19) r = {1'b1, 3'd2};
    else if (op <= 6'd25) r = {1'b1, 3'd3};
    else if (op <= 6'd33) r = {1'b1, 3'd4};
    else                  r = {1'b0, 3'd0};
    return r;
  endfunction
endpackage

// ----- hdl/tomasulo_reservation_pools.sv -----
// Five reservation pools with dispatch, wakeup, issue select and a result buffer
// Channels: in_* carries one command word (clear, dispatch, wakeup or issue),
// out_* returns result words; both use valid/ready. No configuration port.
// Each accepted word is fully processed in the cycle it is taken: pool
// update, tag broadcast compare over all 40 slots and lowest-ready select
// per pool. Its results land in a five-entry result register the next cycle.
// Throughput: one word per cycle, while the receiver takes each result, for
// clear, wakeup and dispatch or issue with at most one result; an issue with
// n results holds the input, since the result register drains one word per
// cycle while the receiver is ready. The input is taken again in the cycle
// the final result is taken.
// Clear and wakeup produce no result; an issue with nothing ready none too.
// Reset empties every pool and the result register. A stalled receiver
// holds the current result word and blocks new input while any result word
// is pending.
module tomasulo_reservation_pools (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tp_pkg::in_t   in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tp_pkg::out_t  out_data
);
  import tp_pkg::*;

  logic        busy_r   [NSLOTS];
  logic        busy_nxt [NSLOTS];
  logic [5:0]  op_r     [NSLOTS];
  logic [5:0]  op_nxt   [NSLOTS];
  logic [31:0] v1_r     [NSLOTS];
  logic [31:0] v1_nxt   [NSLOTS];
  logic [31:0] v2_r     [NSLOTS];
  logic [31:0] v2_nxt   [NSLOTS];
  logic        w1p_r    [NSLOTS];
  logic        w1p_nxt  [NSLOTS];
  logic [4:0]  w1t_r    [NSLOTS];
  logic [4:0]  w1t_nxt  [NSLOTS];
  logic        w2p_r    [NSLOTS];
  logic        w2p_nxt  [NSLOTS];
  logic [4:0]  w2t_r    [NSLOTS];
  logic [4:0]  w2t_nxt  [NSLOTS];
  logic [31:0] off_r    [NSLOTS];
  logic [31:0] off_nxt  [NSLOTS];
  logic [4:0]  dst_r    [NSLOTS];
  logic [4:0]  dst_nxt  [NSLOTS];

  out_t         res_r   [RES_MAX];
  out_t         res_nxt [RES_MAX];
  logic [RES_MAX-1:0] pend_r, pend_nxt;

  logic in_fire, out_fire, out_last;
  logic [2:0] sel;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign out_valid = |pend_r;
  assign out_last  = (pend_r & (pend_r - RES_MAX'(1))) == '0;
  assign in_ready  = !(|pend_r) || (out_ready && out_last);

  always_comb begin
    sel = 3'd0;
    for (int r = RES_MAX - 1; r >= 0; r--) begin
      if (pend_r[r]) sel = 3'(r);
    end
    out_data      = res_r[sel];
    out_data.last = out_last;
  end

  always_comb begin
    logic [3:0] pd;
    logic found;
    logic [RES_MAX-1:0] fresh;
    logic [4:0] fm;
    logic all_busy;
    int i;
    for (int k = 0; k < NSLOTS; k++) begin
      busy_nxt[k] = busy_r[k];
      op_nxt[k]   = op_r[k];
      v1_nxt[k]   = v1_r[k];
      v2_nxt[k]   = v2_r[k];
      w1p_nxt[k]  = w1p_r[k];
      w1t_nxt[k]  = w1t_r[k];
      w2p_nxt[k]  = w2p_r[k];
      w2t_nxt[k]  = w2t_r[k];
      off_nxt[k]  = off_r[k];
      dst_nxt[k]  = dst_r[k];
    end
    for (int r = 0; r < RES_MAX; r++) res_nxt[r] = res_r[r];
    pend_nxt = out_fire ? (pend_r & (pend_r - RES_MAX'(1))) : pend_r;
    fresh = '0;
    pd = '0;
    found = 1'b0;
    i = 0;
    if (in_fire) begin
      unique case (in_data.func)
        FN_CLEAR: begin
          for (int k = 0; k < NSLOTS; k++) busy_nxt[k] = 1'b0;
        end
        FN_DISPATCH: begin
          pd = pool_of(in_data.op);
          res_nxt[0] = '0;
          res_nxt[0].pool = pd[2:0];
          if (!pd[3]) begin
            res_nxt[0].kind = KIND_UNKNOWN;
          end else begin
            for (int s = 0; s < SLOTS_PER_POOL; s++) begin
              i = int'(pd[2:0]) * SLOTS_PER_POOL + s;
              if (!found && !busy_r[i]) begin
                found       = 1'b1;
                busy_nxt[i] = 1'b1;
                op_nxt[i]   = in_data.op;
                v1_nxt[i]   = in_data.src1_value;
                v2_nxt[i]   = in_data.src2_value;
                w1p_nxt[i]  = in_data.src1_pending;
                w1t_nxt[i]  = in_data.src1_tag;
                w2p_nxt[i]  = in_data.src2_pending;
                w2t_nxt[i]  = in_data.src2_tag;
                off_nxt[i]  = in_data.imm;
                dst_nxt[i]  = in_data.rob_tag;
              end
            end
            res_nxt[0].kind = found ? KIND_ACCEPT : KIND_FULL;
          end
          fresh[0] = 1'b1;
        end
        FN_WAKEUP: begin
          if ({1'b0, in_data.rob_tag} < 6'(TAG_COUNT)) begin
            for (int k = 0; k < NSLOTS; k++) begin
              if (busy_r[k] && w1p_r[k] && w1t_r[k] == in_data.rob_tag) begin
                v1_nxt[k]  = in_data.src1_value;
                w1p_nxt[k] = 1'b0;
                w1t_nxt[k] = '0;
              end
              if (busy_r[k] && w2p_r[k] && w2t_r[k] == in_data.rob_tag) begin
                v2_nxt[k]  = in_data.src1_value;
                w2p_nxt[k] = 1'b0;
                w2t_nxt[k] = '0;
              end
            end
          end
        end
        FN_ISSUE: begin
          for (int p = 0; p < POOL_COUNT; p++) begin
            found = 1'b0;
            res_nxt[p] = '0;
            if (in_data.unit_free[p]) begin
              for (int s = 0; s < SLOTS_PER_POOL; s++) begin
                i = p * SLOTS_PER_POOL + s;
                if (!found && busy_r[i] && !w1p_r[i] && !w2p_r[i]) begin
                  found = 1'b1;
                  busy_nxt[i] = 1'b0;
                  res_nxt[p].pool     = 3'(p);
                  res_nxt[p].dest_tag = dst_r[i];
                  res_nxt[p].op_out   = op_r[i];
                  if (p != LS_POOL) begin
                    res_nxt[p].kind      = KIND_ALU;
                    res_nxt[p].operand_a = v1_r[i];
                    res_nxt[p].operand_b = v2_r[i];
                  end else if (op_r[i] <= OP_LAST_LOAD) begin
                    res_nxt[p].kind      = KIND_LOAD;
                    res_nxt[p].operand_a = v1_r[i] + v2_r[i];
                  end else begin
                    res_nxt[p].kind      = KIND_STORE;
                    res_nxt[p].operand_a = v1_r[i] + off_r[i];
                    res_nxt[p].operand_b = v2_r[i];
                  end
                end
              end
            end
            fresh[p] = found;
          end
        end
        default: ;
      endcase
    end
    fm = '0;
    for (int p = 0; p < POOL_COUNT; p++) begin
      all_busy = 1'b1;
      for (int s = 0; s < SLOTS_PER_POOL; s++) begin
        if (!busy_nxt[p * SLOTS_PER_POOL + s]) all_busy = 1'b0;
      end
      fm[p] = all_busy;
    end
    for (int r = 0; r < RES_MAX; r++) begin
      if (fresh[r]) res_nxt[r].full_mask = fm;
    end
    pend_nxt = pend_nxt | fresh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      for (int k = 0; k < NSLOTS; k++) busy_r[k] <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      for (int k = 0; k < NSLOTS; k++) busy_r[k] <= busy_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSLOTS; k++) begin
      op_r[k]  <= op_nxt[k];
      v1_r[k]  <= v1_nxt[k];
      v2_r[k]  <= v2_nxt[k];
      w1p_r[k] <= w1p_nxt[k];
      w1t_r[k] <= w1t_nxt[k];
      w2p_r[k] <= w2p_nxt[k];
      w2t_r[k] <= w2t_nxt[k];
      off_r[k] <= off_nxt[k];
      dst_r[k] <= dst_nxt[k];
    end
    for (int r = 0; r < RES_MAX; r++) res_r[r] <= res_nxt[r];
  end

`include "tomasulo_reservation_pools_assert.svh"
  `TP_ASSERT_NEXT(a_dispatch_one, in_fire && in_data.func == FN_DISPATCH, $countones(pend_r) == 1, "dispatch must leave exactly one result")
  `TP_ASSERT_NEXT(a_clear_none, in_fire && in_data.func == FN_CLEAR, pend_r == '0, "clear must leave no result")
  `TP_ASSERT_NOW(a_stall_block, out_valid && !out_ready, !in_ready, "input taken while results stall")
  `TP_ASSERT_NOW(a_ready_drain, in_ready, !out_valid || (out_ready && out_last), "input taken with results left")
endmodule

// ----- tb/tomasulo_reservation_pools_tb.sv -----
// Self-checking testbench for the reservation pools: dispatch, wakeup, issue and clear words
module tomasulo_reservation_pools_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  tomasulo_reservation_pools uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic busy;
    logic [5:0] op;
    logic [31:0] va, vb, offs;
    logic wa, wb;
    logic [4:0] ta, tb, dest;
  } entry_t;

  entry_t pool_slots[NSLOTS];
  out_t expected_words[$];
  int errors = 0;
  int cycles = 0;
  logic rx_stall_mode = 1'b0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic logic [4:0] pools_full();
    logic [4:0] m;
    m = '0;
    for (int p = 0; p < POOL_COUNT; p++) begin
      m[p] = 1'b1;
      for (int s = 0; s < SLOTS_PER_POOL; s++)
        if (!pool_slots[p*SLOTS_PER_POOL+s].busy) m[p] = 1'b0;
    end
    return m;
  endfunction

  function automatic int op_pool(logic [5:0] op);
    if (op <= 3) return 0;
    if (op <= 13) return 1;
    if (op <= 19) return 2;
    if (op <= 25) return 3;
    if (op <= 33) return LS_POOL;
    return -1;
  endfunction

  task automatic predict_pools(input in_t w);
    out_t r, q[$];
    int pl, slot, i;
    q = {};
    case (w.func)
      FN_CLEAR: for (i = 0; i < NSLOTS; i++) pool_slots[i].busy = 1'b0;
      FN_DISPATCH: begin
        r = '0;
        pl = op_pool(w.op);
        if (pl < 0) begin
          r.kind = KIND_UNKNOWN;
        end else begin
          r.pool = 3'(pl);
          slot = -1;
          for (int s = 0; s < SLOTS_PER_POOL; s++)
            if (slot < 0 && !pool_slots[pl*SLOTS_PER_POOL+s].busy) slot = pl*SLOTS_PER_POOL+s;
          if (slot < 0) begin
            r.kind = KIND_FULL;
          end else begin
            r.kind = KIND_ACCEPT;
            pool_slots[slot] = '{1'b1, w.op, w.src1_value, w.src2_value, w.imm,
                                 w.src1_pending, w.src2_pending, w.src1_tag, w.src2_tag,
                                 w.rob_tag};
          end
        end
        r.full_mask = pools_full();
        r.last = 1'b1;
        q.push_back(r);
      end
      FN_WAKEUP: begin
        for (i = 0; i < NSLOTS; i++) begin
          if (!pool_slots[i].busy) continue;
          if (pool_slots[i].wa && pool_slots[i].ta == w.rob_tag) begin
            pool_slots[i].va = w.src1_value;
            pool_slots[i].wa = 1'b0;
          end
          if (pool_slots[i].wb && pool_slots[i].tb == w.rob_tag) begin
            pool_slots[i].vb = w.src1_value;
            pool_slots[i].wb = 1'b0;
          end
        end
      end
      default: begin
        for (int p = 0; p < POOL_COUNT; p++) begin
          if (!w.unit_free[p]) continue;
          for (int s = 0; s < SLOTS_PER_POOL; s++) begin
            i = p*SLOTS_PER_POOL + s;
            if (pool_slots[i].busy && !pool_slots[i].wa && !pool_slots[i].wb) begin
              r = '0;
              r.pool = 3'(p);
              r.dest_tag = pool_slots[i].dest;
              r.op_out = pool_slots[i].op;
              if (p != LS_POOL) begin
                r.kind = KIND_ALU;
                r.operand_a = pool_slots[i].va;
                r.operand_b = pool_slots[i].vb;
              end else if (pool_slots[i].op <= OP_LAST_LOAD) begin
                r.kind = KIND_LOAD;
                r.operand_a = pool_slots[i].va + pool_slots[i].vb;
              end else begin
                r.kind = KIND_STORE;
                r.operand_a = pool_slots[i].va + pool_slots[i].offs;
                r.operand_b = pool_slots[i].vb;
              end
              pool_slots[i].busy = 1'b0;
              q.push_back(r);
              break;
            end
          end
        end
        foreach (q[k]) q[k].full_mask = pools_full();
        if (q.size() > 0) q[q.size()-1].last = 1'b1;
      end
    endcase
    foreach (q[k]) expected_words.push_back(q[k]);
  endtask

  task automatic send_word(input in_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    predict_pools(w);
  endtask

  function automatic in_t rand_word(logic [1:0] fn);
    in_t w;
    w = '0;
    w.func = func_t'(fn);
    w.op = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 33));
    w.src1_pending = ($urandom_range(0, 3) == 0);
    w.src2_pending = ($urandom_range(0, 3) == 0);
    w.src1_tag = 5'($urandom_range(0, 7));
    w.src2_tag = 5'($urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0) begin
      w.src1_tag = 5'($urandom);
      w.src2_tag = 5'($urandom);
    end
    w.src1_value = $urandom;
    w.src2_value = $urandom;
    w.imm = $urandom;
    w.unit_free = 5'($urandom);
    w.rob_tag = (fn == FN_WAKEUP && $urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 7))
                                                                : 5'($urandom);
    return w;
  endfunction

  function automatic in_t make_word(logic [1:0] fn, logic [5:0] op, logic [4:0] free);
    in_t w;
    w = rand_word(fn);
    w.op = op;
    w.unit_free = free;
    w.src1_pending = 1'b0;
    w.src2_pending = 1'b0;
    return w;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic test_dispatch_kinds();
    in_t w;
    logic [5:0] ops [8] = '{6'd0, 6'd13, 6'd19, 6'd25, 6'd30, 6'd33, 6'd34, 6'd63};
    foreach (ops[k]) begin
      w = make_word(FN_DISPATCH, ops[k], 5'h1f);
      send_word(w);
    end
    w = make_word(FN_ISSUE, 6'd0, 5'h1f);
    send_word(w);
  endtask

  task automatic test_extremes_and_wakeup();
    in_t w;
    w = make_word(FN_DISPATCH, 6'd31, 5'h0);
    w.src1_value = '1; w.imm = '1; w.src2_value = '1; w.rob_tag = 5'd31;
    w.src1_pending = 1'b1; w.src1_tag = 5'd31;
    send_word(w);
    w = make_word(FN_DISPATCH, 6'd2, 5'h0);
    w.src2_pending = 1'b1; w.src2_tag = 5'd31;
    send_word(w);
    w = make_word(FN_ISSUE, 6'd0, 5'h1f);
    send_word(w);
    w = make_word(FN_WAKEUP, 6'd0, 5'h0);
    w.rob_tag = 5'd31; w.src1_value = 32'hffff_fffe;
    send_word(w);
    w = make_word(FN_ISSUE, 6'd0, 5'h0f);
    send_word(w);
    w = make_word(FN_ISSUE, 6'd0, 5'h1f);
    send_word(w);
  endtask

  task automatic test_pool_full_and_clear();
    in_t w;
    for (int k = 0; k < SLOTS_PER_POOL + 1; k++) begin
      w = make_word(FN_DISPATCH, 6'd20, 5'h0);
      send_word(w);
    end
    w = make_word(FN_CLEAR, 6'd0, 5'h0);
    send_word(w);
    w = make_word(FN_ISSUE, 6'd0, 5'h1f);
    send_word(w);
  endtask

  task automatic test_random_traffic(input int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 2) send_word(rand_word(FN_CLEAR));
      else if (r < 50) send_word(rand_word(FN_DISPATCH));
      else if (r < 70) send_word(rand_word(FN_WAKEUP));
      else send_word(rand_word(FN_ISSUE));
      if (k == count / 2) wait_drained();
      if (k == count / 3) rx_stall_mode = 1'b1;
      if (k == 2 * count / 3) rx_stall_mode = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[tomasulo_reservation_pools] ERROR");
      $finish;
    end
  end

  int rx_hold = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word %p", $time, out_data);
        errors++;
      end else begin
        out_t e;
        e = expected_words.pop_front();
        if (e.kind !== out_data.kind || e.pool !== out_data.pool ||
            e.operand_a !== out_data.operand_a || e.operand_b !== out_data.operand_b ||
            e.dest_tag !== out_data.dest_tag || e.op_out !== out_data.op_out ||
            e.full_mask !== out_data.full_mask || e.last !== out_data.last) begin
          $display("%0t mismatch expected %p actual %p", $time, e, out_data);
          errors++;
        end
      end
    end
    if (!rx_stall_mode) begin
      out_ready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      rx_hold <= gap_len();
      out_ready <= 1'b1;
    end
  end

  initial begin
    for (int i = 0; i < NSLOTS; i++) pool_slots[i] = '{default: '0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_dispatch_kinds();
    rx_stall_mode = 1'b1;
    test_extremes_and_wakeup();
    test_pool_full_and_clear();
    rx_stall_mode = 1'b0;
    test_random_traffic(75);
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("[tomasulo_reservation_pools] OK");
    end else begin
      $display("[tomasulo_reservation_pools] ERROR");
    end
    $finish;
  end
endmodule
